/* rtl/dwtafb_pkg.sv */
// ----------------------------------------------------------------------------
// dwtafb_pkg
// Shared types, constants and tap tables of the wavelet analysis filter bank.
// ----------------------------------------------------------------------------
package dwtafb_pkg;

  // fixed field widths of the streaming and register ports
  localparam int SAMPLE_IN_W = 16;
  localparam int OUT_WIDTH   = 36;
  localparam int TDATA_OUT_W = 2 * OUT_WIDTH;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 3;
  localparam int WSEL_W      = 2;

  // defaults of the top level parameters
  localparam int DEF_MAX_TAPS     = 8;
  localparam int DEF_SAMPLE_WIDTH = 16;
  localparam int DEF_COEF_WIDTH   = 16;

  // register index taken from paddr bit 2
  localparam logic REG_WAVELET_SEL = 1'b0;

  // wavelet selection codes
  typedef enum logic [WSEL_W-1:0] {
    WAV_DB1 = 2'd0,
    WAV_DB2 = 2'd1,
    WAV_DB3 = 2'd2,
    WAV_DB4 = 2'd3
  } wavelet_e;

  // low-pass scaling filter taps in q1.15, one row per wavelet
  localparam logic signed [15:0] Q15_TAPS [4][8] = '{
    '{16'sd23170, 16'sd23170, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd15826, 16'sd27411, 16'sd7345, -16'sd4240,
      16'sd0, 16'sd0, 16'sd0, 16'sd0},
    '{16'sd10901, 16'sd26440, 16'sd15069, -16'sd4424,
      -16'sd2800, 16'sd1154, 16'sd0, 16'sd0},
    '{16'sd7549, 16'sd23424, 16'sd20673, -16'sd917,
      -16'sd6129, 16'sd1011, 16'sd1078, -16'sd347}
  };

endpackage

/* rtl/dwt_analysis_filter_bank_core.sv */
// ----------------------------------------------------------------------------
// dwt_analysis_filter_bank_core
// One level of a Daubechies analysis filter bank with a shared multiplier pair.
// ----------------------------------------------------------------------------
// an even-index sample gives its pair once its L taps have gone through the
//   multiply-accumulate pair, one product stage and one load; the load waits on a stalled output
// an odd-index sample only shifts the delay line; a new sample is taken only after the
//   tap loop over the single multiplier pair, the load and the shift of the last one;
//   a last sample adds up to L/2-1 flush pairs
// reset: asynchronous active low, clears the delay line, parity and wavelet_select
module dwt_analysis_filter_bank_core #(
  parameter int MAX_TAPS     = dwtafb_pkg::DEF_MAX_TAPS,
  parameter int SAMPLE_WIDTH = dwtafb_pkg::DEF_SAMPLE_WIDTH,
  parameter int COEF_WIDTH   = dwtafb_pkg::DEF_COEF_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input stream, tdata: sample[15:0]; tlast: last_sample
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [dwtafb_pkg::SAMPLE_IN_W-1:0]  s_axis_tdata_i,
  input  logic                                s_axis_tlast_i,
  // output stream, tdata: approx_out[35:0], detail_out[71:36]; tlast: last_out
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [dwtafb_pkg::TDATA_OUT_W-1:0]  m_axis_tdata_o,
  output logic                                m_axis_tlast_o,
  // register port
  input  logic                                psel_i,
  input  logic                                penable_i,
  input  logic                                pwrite_i,
  input  logic [dwtafb_pkg::APB_ADDR_W-1:0]   paddr_i,
  input  logic [dwtafb_pkg::APB_DATA_W-1:0]   pwdata_i,
  output logic [dwtafb_pkg::APB_DATA_W-1:0]   prdata_o,
  output logic                                pready_o
);
  import dwtafb_pkg::*;

  localparam int DEPTH = MAX_TAPS - 1;
  localparam int DW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW    = $clog2(MAX_TAPS + 1);
  localparam int PAW   = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int PDW   = SAMPLE_WIDTH + COEF_WIDTH + 1;
  localparam int CSHL  = (COEF_WIDTH >= 16) ? COEF_WIDTH - 16 : 0;
  localparam int CSHR  = (COEF_WIDTH < 16) ? 16 - COEF_WIDTH : 0;
  localparam int RND   = (2 ** CSHR) / 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_PUSH,
    S_SHIFT
  } state_e;

  // q1.15 tap brought to the coefficient scale, rounding half up when narrowed
  function automatic logic signed [COEF_WIDTH-1:0] scale_coef(input logic signed [15:0] q);
    logic signed [31:0] w;
    w = 32'(q);
    if (COEF_WIDTH >= 16) begin
      w = w <<< CSHL;
    end else begin
      w = (w + 32'sd0 + 32'(RND)) >>> CSHR;
    end
    return w[COEF_WIDTH-1:0];
  endfunction

  state_e                          state_q;
  logic [WSEL_W-1:0]               wsel_q;
  logic signed [SAMPLE_WIDTH-1:0]  delay_q [DEPTH];
  logic                            parity_q;
  logic signed [SAMPLE_WIDTH-1:0]  x_q;
  logic                            last_q;
  logic                            flush_q;
  logic [KW-1:0]                   owed_q;
  logic [KW-1:0]                   k_q;
  logic signed [PAW-1:0]           pa_q;
  logic signed [PDW-1:0]           pd_q;
  logic [OUT_WIDTH-1:0]            acc_a_q;
  logic [OUT_WIDTH-1:0]            acc_d_q;
  logic                            out_valid_q;
  logic [OUT_WIDTH-1:0]            out_a_q;
  logic [OUT_WIDTH-1:0]            out_d_q;
  logic                            out_last_q;

  // filter length, haar when the selection is longer than the delay line allows
  logic [3:0]        nat_len;
  logic              fallback;
  logic [WSEL_W-1:0] sel_eff;
  logic [KW-1:0]     len_w;
  logic [KW-1:0]     owed_init;

  assign nat_len   = {1'b0, wsel_q, 1'b0} + 4'd2;
  assign fallback  = nat_len > 4'(MAX_TAPS);
  assign sel_eff   = fallback ? WAV_DB1 : wsel_q;
  assign len_w     = fallback ? KW'(2) : KW'(nat_len);
  assign owed_init = (len_w >> 1) - KW'(1);

  // sample and tap selection for the current step of the tap loop
  logic [KW-1:0]                  mir_k;
  logic [DW-1:0]                  didx;
  logic signed [SAMPLE_WIDTH-1:0] tap_s;
  logic signed [COEF_WIDTH-1:0]   c_lp;
  logic signed [COEF_WIDTH-1:0]   c_hp_raw;
  logic signed [COEF_WIDTH:0]     c_hp;
  logic signed [PAW-1:0]          pa_d;
  logic signed [PDW-1:0]          pd_d;

  assign mir_k    = len_w - KW'(1) - k_q;
  assign didx     = DW'(k_q - KW'(1));
  assign tap_s    = (k_q == '0) ? x_q : delay_q[didx];
  assign c_lp     = scale_coef(Q15_TAPS[sel_eff][3'(k_q)]);
  assign c_hp_raw = scale_coef(Q15_TAPS[sel_eff][3'(mir_k)]);
  assign c_hp     = k_q[0] ? -(COEF_WIDTH+1)'(c_hp_raw) : (COEF_WIDTH+1)'(c_hp_raw);

  // shared multiplier pair
  assign pa_d = PAW'(tap_s) * PAW'(c_lp);
  assign pd_d = PDW'(tap_s) * PDW'(c_hp);

  // products brought to the wrapped output width
  logic signed [63:0] pa64;
  logic signed [63:0] pd64;
  assign pa64 = 64'(pa_q);
  assign pd64 = 64'(pd_q);

  // input sample: low SAMPLE_WIDTH bits of the zero-extended field
  logic [31:0]                    s_ext;
  logic signed [SAMPLE_WIDTH-1:0] s_x;
  assign s_ext = 32'(s_axis_tdata_i);
  assign s_x   = $signed(s_ext[SAMPLE_WIDTH-1:0]);

  // handshakes
  logic in_fire;
  logic out_free;
  logic cfg_wr;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign cfg_wr          = psel_i && penable_i && pwrite_i && pready_o;

  // final step of a signal, state goes back to its cleared values
  logic sig_end;
  assign sig_end = last_q && (owed_q == '0);

  // sequencer, datapath registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      wsel_q      <= WAV_DB1;
      parity_q    <= 1'b0;
      x_q         <= '0;
      last_q      <= 1'b0;
      flush_q     <= 1'b0;
      owed_q      <= '0;
      k_q         <= '0;
      pa_q        <= '0;
      pd_q        <= '0;
      acc_a_q     <= '0;
      acc_d_q     <= '0;
      out_valid_q <= 1'b0;
      out_a_q     <= '0;
      out_d_q     <= '0;
      out_last_q  <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        delay_q[i] <= '0;
      end
    end else begin
      // register write
      if (cfg_wr && (paddr_i[2] == REG_WAVELET_SEL)) begin
        wsel_q <= pwdata_i[WSEL_W-1:0];
      end

      // output valid: set on a loaded pair, cleared once the transaction is taken
      if ((state_q == S_PUSH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            x_q     <= s_x;
            last_q  <= s_axis_tlast_i;
            flush_q <= 1'b0;
            owed_q  <= owed_init;
            k_q     <= '0;
            acc_a_q <= '0;
            acc_d_q <= '0;
            state_q <= parity_q ? S_SHIFT : S_MAC;
          end
        end
        S_MAC: begin
          // product of tap k, accumulate product of tap k-1
          if (k_q < len_w) begin
            pa_q <= pa_d;
            pd_q <= pd_d;
          end
          if (k_q != '0) begin
            acc_a_q <= acc_a_q + pa64[OUT_WIDTH-1:0];
            acc_d_q <= acc_d_q + pd64[OUT_WIDTH-1:0];
          end
          if (k_q == len_w) begin
            state_q <= S_PUSH;
          end else begin
            k_q <= k_q + KW'(1);
          end
        end
        S_PUSH: begin
          if (out_free) begin
            out_a_q     <= acc_a_q;
            out_d_q     <= acc_d_q;
            out_last_q  <= last_q && (flush_q ? (owed_q == KW'(1)) : (owed_q == '0));
            if (flush_q) begin
              owed_q <= owed_q - KW'(1);
            end
            state_q <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          // advance the delay line, or clear it at the end of a signal
          for (int i = DEPTH - 1; i > 0; i--) begin
            delay_q[i] <= sig_end ? '0 : delay_q[i-1];
          end
          delay_q[0] <= sig_end ? '0 : x_q;
          parity_q   <= !sig_end && !parity_q;
          // decide on a further flush step
          if (last_q && (owed_q != '0)) begin
            x_q     <= '0;
            flush_q <= 1'b1;
            k_q     <= '0;
            acc_a_q <= '0;
            acc_d_q <= '0;
            state_q <= parity_q ? S_MAC : S_SHIFT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // outputs
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_d_q, out_a_q};
  assign m_axis_tlast_o  = out_last_q;
  assign pready_o        = 1'b1;
  assign prdata_o        = (paddr_i[2] == REG_WAVELET_SEL) ?
                           APB_DATA_W'(wsel_q) : '0;

`ifndef SYNTH
  // tap counter never runs past the filter length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC) |-> (k_q <= len_w))
    else $error("tap counter beyond filter length");

  // the end of a signal leaves even parity for the next one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SHIFT && last_q && owed_q == '0) |=> (!parity_q && state_q == S_IDLE))
    else $error("state not cleared after the end of a signal");

  // a stalled result pair is not overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |=> (out_valid_q && $stable(out_a_q)
      && $stable(out_d_q) && $stable(out_last_q)))
    else $error("pending result overwritten");

  // flush debt never exceeds half the filter length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> (owed_q < KW'(MAX_TAPS / 2)))
    else $error("flush count out of range");
`endif

endmodule
